@@ design/soa_pkg.sv @@
// Shared types, codes and default sizes for the slab object allocator.
package soa_pkg;

    localparam int NUM_SLABS_DEF   = 16;
    localparam int MAX_OBJECTS_DEF = 256;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef struct packed {
        logic       func;
        logic [3:0] slab_index;
        logic [7:0] object_index;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [3:0]  granted_slab;
        logic [7:0]  granted_object;
        logic [12:0] live_objects;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SLOT,
        S_EXEC
    } t_state;

endpackage

@@ design/soa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/slab_object_allocator.sv @@
// Slab object allocator: top level with slab record and slot memories.
//
// Input channel: i_in_valid / o_in_stall carry one word per operation (allocate or
// free, with slab and slot for a free). Output channel: o_out_valid / i_out_stall
// carry one result word per operation: status, granted slab and slot, and the
// number of live objects afterward. Config: i_cfg_we writes objects_per_slab,
// used for slabs built after the write.
// The accepting edge reads the slab record memory; state S_SLOT then reads the slot
// memory (free-list link and taken bit), and state S_EXEC writes both back and
// registers the result. The next word is taken in S_IDLE once the result register
// is empty or being drained, so no word is taken before the last one is through.
// Slot free lists are built lazily: a per-slab fresh pointer stands in for the
// ascending list, so building a slab costs no memory sweep.
// Reset (synchronous, active low) idles all frames, empties the partial list,
// clears the live count and sets objects_per_slab to 256. No clearing pass.
// While the receiver stalls, the result word holds and no new word is taken.
module slab_object_allocator
    import soa_pkg::*;
#(
    parameter int NUM_SLABS   = NUM_SLABS_DEF,
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_we,
    input  logic [8:0] i_cfg_data
);
    localparam int SLOT_CAP = (MAX_OBJECTS < 256) ? MAX_OBJECTS : 256;
    localparam int SW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int OW = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;
    localparam int CW = $clog2(SLOT_CAP + 1);
    localparam int LW = $clog2(NUM_SLABS + 1);
    localparam int SLOT_DEPTH = NUM_SLABS << OW;
    localparam logic [LW-1:0] LNULL = LW'(NUM_SLABS);

    typedef struct packed {
        logic [CW-1:0] total;
        logic [CW-1:0] inuse;
        logic [CW-1:0] head;
        logic [CW-1:0] fresh;
    } t_rec;

    typedef struct packed {
        logic          taken;
        logic [CW-1:0] next;
    } t_slot;

    t_state r_state, n_state;

    logic [8:0]          r_ops;
    logic [NUM_SLABS-1:0] r_busy;
    logic [LW-1:0]       r_head;
    logic [LW-1:0]       r_pnext [NUM_SLABS];
    logic [LW-1:0]       r_pprev [NUM_SLABS];
    logic [12:0]         r_live;

    logic          r_func, r_build, r_oom, r_bad;
    logic [SW-1:0] r_s;
    logic [7:0]    r_o;
    logic [OW-1:0] r_osel;
    t_rec          r_rec;
    logic          r_ov;
    t_out_word     r_out;

    logic          accept;
    logic          idle_found;
    logic [SW-1:0] idle_frame;
    logic [SW-1:0] acc_s;
    logic          s_in_range;
    logic [CW-1:0] new_total;

    t_rec          rec_rd, rec_cur, rec_wr;
    t_slot         slot_rd, slot_wr;
    logic [OW-1:0] osel;
    logic          rec_we, slot_we;

    logic          alloc_ok, free_ok, fresh_hit, now_full, was_full, now_empty;
    logic          do_push, do_unlink;
    logic [CW-1:0] inuse_up, inuse_dn;

    // lowest idle frame
    always_comb begin
        idle_found = 1'b0;
        idle_frame = '0;
        for (int i = NUM_SLABS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                idle_found = 1'b1;
                idle_frame = SW'(i);
            end
        end
    end

    always_comb begin
        if (r_ops == 9'd0) begin
            new_total = CW'(1);
        end else if (r_ops > 9'(SLOT_CAP)) begin
            new_total = CW'(SLOT_CAP);
        end else begin
            new_total = CW'(r_ops);
        end
    end

    assign s_in_range = (32'(i_in_word.slab_index) < NUM_SLABS);

    always_comb begin
        if (i_in_word.func == FN_FREE) begin
            acc_s = SW'(i_in_word.slab_index);
        end else if (r_head != LNULL) begin
            acc_s = r_head[SW-1:0];
        end else begin
            acc_s = idle_frame;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_SLOT;
            S_SLOT: n_state = S_EXEC;
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        rec_we     = 1'b0;
        slot_we    = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_stall = r_ov && i_out_stall;
            S_SLOT: o_in_stall = 1'b1;
            S_EXEC: begin
                rec_we  = alloc_ok || free_ok;
                slot_we = alloc_ok || free_ok;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    soa_ram #(.WIDTH($bits(t_rec)), .DEPTH(1 << SW)) u_rec_ram (
        .i_clk  (i_clk),
        .i_we   (rec_we),
        .i_waddr(r_s),
        .i_wdata(rec_wr),
        .i_raddr(acc_s),
        .o_rdata(rec_rd)
    );

    // a freshly built slab has no record in memory yet
    always_comb begin
        if (r_build) begin
            rec_cur.total = new_total;
            rec_cur.inuse = '0;
            rec_cur.head  = '0;
            rec_cur.fresh = '0;
        end else begin
            rec_cur = rec_rd;
        end
        osel = (r_func == FN_FREE) ? r_o[OW-1:0] : rec_cur.head[OW-1:0];
    end

    soa_ram #(.WIDTH($bits(t_slot)), .DEPTH(SLOT_DEPTH)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr({r_s, r_osel}),
        .i_wdata(slot_wr),
        .i_raddr({r_s, osel}),
        .o_rdata(slot_rd)
    );

    // execute step
    always_comb begin
        alloc_ok  = (r_state == S_EXEC) && (r_func == FN_ALLOC) && !r_oom;
        free_ok   = (r_state == S_EXEC) && (r_func == FN_FREE) && !r_bad && slot_rd.taken
                    && (CW'(r_osel) < r_rec.fresh) && (r_rec.inuse != '0);
        fresh_hit = (CW'(r_osel) == r_rec.fresh);
        inuse_up  = r_rec.inuse + CW'(1);
        inuse_dn  = r_rec.inuse - CW'(1);
        now_full  = inuse_up >= r_rec.total;
        was_full  = r_rec.inuse >= r_rec.total;
        now_empty = (inuse_dn == '0);
        rec_wr    = r_rec;
        slot_wr   = '0;
        do_push   = 1'b0;
        do_unlink = 1'b0;
        if (alloc_ok) begin
            rec_wr.inuse  = inuse_up;
            rec_wr.head   = fresh_hit ? (r_rec.head + CW'(1)) : slot_rd.next;
            rec_wr.fresh  = fresh_hit ? (r_rec.fresh + CW'(1)) : r_rec.fresh;
            slot_wr.taken = 1'b1;
            slot_wr.next  = slot_rd.next;
            do_push       = r_build && !now_full;
            do_unlink     = !r_build && now_full;
        end else if (free_ok) begin
            rec_wr.inuse  = inuse_dn;
            rec_wr.head   = CW'(r_osel);
            slot_wr.taken = 1'b0;
            slot_wr.next  = r_rec.head;
            do_push       = !now_empty && was_full;
            do_unlink     = now_empty && !was_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ops   <= 9'd256;
            r_busy  <= '0;
            r_head  <= LNULL;
            r_live  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_ops <= i_cfg_data;
            end
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_EXEC) begin
                r_ov <= 1'b1;
                if (alloc_ok) begin
                    r_busy[r_s] <= 1'b1;
                    r_live      <= r_live + 13'd1;
                end else if (free_ok) begin
                    if (now_empty) begin
                        r_busy[r_s] <= 1'b0;
                    end
                    if (r_live != '0) begin
                        r_live <= r_live - 13'd1;
                    end
                end
                if (do_push) begin
                    r_pprev[r_s] <= LNULL;
                    r_pnext[r_s] <= r_head;
                    if (r_head != LNULL) begin
                        r_pprev[r_head[SW-1:0]] <= LW'(r_s);
                    end
                    r_head <= LW'(r_s);
                end else if (do_unlink) begin
                    if (r_pprev[r_s] != LNULL) begin
                        r_pnext[r_pprev[r_s][SW-1:0]] <= r_pnext[r_s];
                    end else begin
                        r_head <= r_pnext[r_s];
                    end
                    if (r_pnext[r_s] != LNULL) begin
                        r_pprev[r_pnext[r_s][SW-1:0]] <= r_pprev[r_s];
                    end
                end
            end
        end
    end

    // operation payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_in_word.func;
            r_s     <= acc_s;
            r_o     <= i_in_word.object_index;
            r_build <= (i_in_word.func == FN_ALLOC) && (r_head == LNULL) && idle_found;
            r_oom   <= (i_in_word.func == FN_ALLOC) && (r_head == LNULL) && !idle_found;
            r_bad   <= !s_in_range || !r_busy[acc_s];
        end
        if (r_state == S_SLOT) begin
            r_rec  <= rec_cur;
            r_osel <= osel;
            if ((r_func == FN_FREE) && ({1'b0, r_o} >= 9'(rec_cur.total))) begin
                r_bad <= 1'b1;
            end
        end
        if (r_state == S_EXEC) begin
            r_out.granted_slab   <= alloc_ok ? 4'(r_s) : 4'd0;
            r_out.granted_object <= alloc_ok ? 8'(r_osel) : 8'd0;
            r_out.live_objects   <= alloc_ok ? (r_live + 13'd1)
                                  : (free_ok && r_live != '0) ? (r_live - 13'd1) : r_live;
            if (r_func == FN_ALLOC) begin
                r_out.status <= r_oom ? ST_OOM : ST_OK;
            end else begin
                r_out.status <= free_ok ? ST_OK : ST_BAD_FREE;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

endmodule

@@ design/soa_checker.sv @@
// Port-level checker for the slab object allocator, bound to the top level.
module soa_checker
    import soa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

    a_no_take_while_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("word taken while result blocked");

    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != ST_OK) |->
        (o_out_word.granted_slab == 4'd0 && o_out_word.granted_object == 8'd0))
        else $error("grant reported on failed operation");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word taken while busy");
endmodule

bind slab_object_allocator soa_checker u_soa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_word (o_out_word)
);
